// ===== hdl/depth_pixel_to_point_core_defines.svh =====
// Assertion macros shared by the point cloud core.
`ifndef DEPTH_PIXEL_TO_POINT_CORE_DEFINES_SVH
`define DEPTH_PIXEL_TO_POINT_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define DP2P_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A trigger that must be followed by an outcome a fixed number of cycles later.
`define DP2P_ASSERT_AFTER(label, trig, cycles, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (trig) |-> ##cycles (expr)) else $error(msg);

`endif

// ===== hdl/dp2p_pkg.sv =====
package dp2p_pkg;

  // Fixed field widths.
  localparam int ColumnW = 12;
  localparam int DepthW = 16;
  localparam int CenterW = 16;
  localparam int InvW = 24;
  localparam int ColorW = 8;
  localparam int PointW = 32;
  localparam int FracBits = 24;

  // Configuration port.
  localparam int CfgIndexW = 3;
  localparam int CfgDataW = 24;

  localparam logic [CfgIndexW-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_INV_FOCAL_X = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_INV_FOCAL_Y = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_COLOR_ORDER = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_VOID_RED = 3'd5;
  localparam logic [CfgIndexW-1:0] REG_VOID_GREEN = 3'd6;
  localparam logic [CfgIndexW-1:0] REG_VOID_BLUE = 3'd7;

  // Color byte orders.
  localparam logic [1:0] ORDER_RGB = 2'd0;
  localparam logic [1:0] ORDER_BGR = 2'd1;
  localparam logic [1:0] ORDER_MONO = 2'd2;

  typedef struct packed {
    logic [ColumnW-1:0] column;
    logic [ColumnW-1:0] row;
    logic [DepthW-1:0]  depth_mm;
    logic [ColorW-1:0]  color_byte0;
    logic [ColorW-1:0]  color_byte1;
    logic [ColorW-1:0]  color_byte2;
  } pixel_t;

  typedef struct packed {
    logic signed [PointW-1:0] point_x;
    logic signed [PointW-1:0] point_y;
    logic [DepthW-1:0]        point_z;
    logic                     point_valid;
    logic [ColorW-1:0]        red;
    logic [ColorW-1:0]        green;
    logic [ColorW-1:0]        blue;
  } point_t;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } rgb_t;

endpackage

// ===== hdl/depth_pixel_to_point_core.sv =====
// A pixel accepted at one clock edge shows its point with done high once it
// has passed the stages below; one pixel may be accepted in every non-busy cycle.
// The five stages are offset and color select, depth multiply, focal multiply,
// rounding, and saturation with sign; the two multipliers set the clock rate.
// Reset is synchronous: it clears the pipeline valid bits and the configuration
// registers; busy is set in reset and clears at the first edge after. No back-pressure.
`include "depth_pixel_to_point_core_defines.svh"

module depth_pixel_to_point_core #(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  dp2p_pkg::pixel_t              pixel,
  output logic                          done,
  output dp2p_pkg::point_t              point,
  input  logic                          cfg_write,
  input  logic [dp2p_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [dp2p_pkg::CfgDataW-1:0]  cfg_data
);
  import dp2p_pkg::*;

  // Effective coordinate and depth widths after masking.
  localparam int UBits = (COORD_BITS < ColumnW) ? COORD_BITS : ColumnW;
  localparam int DBits = (DEPTH_BITS < DepthW) ? DEPTH_BITS : DepthW;
  localparam int P1W = CenterW + DBits;
  localparam int P2W = P1W + InvW;
  localparam int SumW = P2W + 1;
  localparam int QW = SumW - FracBits;
  localparam int PipeDepth = 5;
  localparam logic [63:0] PosLimit = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NegLimit = 64'h0000_0000_8000_0000;

  // Configuration registers, lane 0 is X and lane 1 is Y.
  logic [CenterW-1:0] center [2];
  logic [InvW-1:0]    inv_focal [2];
  logic [1:0]         color_order;
  rgb_t               discard_rgb;

  // Pipeline registers.
  logic               s1_valid, s2_valid, s3_valid, s4_valid;
  logic               s1_ok, s2_ok, s3_ok, s4_ok;
  logic               s1_neg [2];
  logic               s2_neg [2];
  logic               s3_neg [2];
  logic               s4_neg [2];
  logic [CenterW-1:0] s1_mag [2];
  logic [P1W-1:0]     s2_prod [2];
  logic [P2W-1:0]     s3_prod [2];
  logic [QW-1:0]      s4_q [2];
  logic [DBits-1:0]   s1_depth, s2_depth, s3_depth, s4_depth;
  rgb_t               s1_rgb, s2_rgb, s3_rgb, s4_rgb;

  // Stage one combinational values.
  logic [UBits-1:0]   coord [2];
  logic [CenterW-1:0] scaled [2];
  logic               neg_next [2];
  logic [CenterW-1:0] mag_next [2];
  logic [DBits-1:0]   depth_next;
  rgb_t               rgb_next;
  logic               ok_next;
  logic               accept;

  // Rounding and saturation values.
  logic [SumW-1:0]       sum [2];
  logic [63:0]           q_ext [2];
  logic [PointW-1:0]     coord_out [2];

  assign accept = start && !busy;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      center[0] <= '0;
      center[1] <= '0;
      inv_focal[0] <= '0;
      inv_focal[1] <= '0;
      color_order <= ORDER_RGB;
      discard_rgb <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CENTER_X:    center[0] <= cfg_data[CenterW-1:0];
        REG_CENTER_Y:    center[1] <= cfg_data[CenterW-1:0];
        REG_INV_FOCAL_X: inv_focal[0] <= cfg_data[InvW-1:0];
        REG_INV_FOCAL_Y: inv_focal[1] <= cfg_data[InvW-1:0];
        REG_COLOR_ORDER: color_order <= cfg_data[1:0];
        REG_VOID_RED:    discard_rgb.red <= cfg_data[ColorW-1:0];
        REG_VOID_GREEN:  discard_rgb.green <= cfg_data[ColorW-1:0];
        REG_VOID_BLUE:   discard_rgb.blue <= cfg_data[ColorW-1:0];
      endcase
    end
  end

  // Stage one: offset from the principal point, color select and validity.
  always_comb begin
    coord[0] = pixel.column[UBits-1:0];
    coord[1] = pixel.row[UBits-1:0];
    for (int l = 0; l < 2; l++) begin
      scaled[l] = CenterW'({coord[l], 4'b0000});
      neg_next[l] = scaled[l] < center[l];
      mag_next[l] = neg_next[l] ? (center[l] - scaled[l]) : (scaled[l] - center[l]);
    end
    depth_next = pixel.depth_mm[DBits-1:0];
    unique case (color_order)
      ORDER_BGR: begin
        rgb_next = '{red: pixel.color_byte2, green: pixel.color_byte1,
                     blue: pixel.color_byte0};
      end
      ORDER_MONO: begin
        rgb_next = '{red: pixel.color_byte0, green: pixel.color_byte0,
                     blue: pixel.color_byte0};
      end
      default: begin
        rgb_next = '{red: pixel.color_byte0, green: pixel.color_byte1,
                     blue: pixel.color_byte2};
      end
    endcase
    ok_next = (depth_next != '0) && (rgb_next != discard_rgb);
  end

  // Stage four: round to nearest, ties away from zero on the magnitude.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum[l] = {1'b0, s3_prod[l]} + (SumW'(1) << (FracBits - 1));
    end
  end

  // Stage five: saturate the magnitude and apply the sign.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q_ext[l] = 64'(s4_q[l]);
      if (!s4_neg[l]) begin
        coord_out[l] = (q_ext[l] > PosLimit) ? PosLimit[PointW-1:0] : q_ext[l][PointW-1:0];
      end else if (q_ext[l] > NegLimit) begin
        coord_out[l] = NegLimit[PointW-1:0];
      end else begin
        coord_out[l] = PointW'(0) - q_ext[l][PointW-1:0];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      done <= s4_valid;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    s1_depth <= depth_next;
    s1_rgb <= rgb_next;
    s1_ok <= ok_next;
    s2_depth <= s1_depth;
    s2_rgb <= s1_rgb;
    s2_ok <= s1_ok;
    s3_depth <= s2_depth;
    s3_rgb <= s2_rgb;
    s3_ok <= s2_ok;
    s4_depth <= s3_depth;
    s4_rgb <= s3_rgb;
    s4_ok <= s3_ok;
    for (int l = 0; l < 2; l++) begin
      s1_neg[l] <= neg_next[l];
      s1_mag[l] <= mag_next[l];
      s2_neg[l] <= s1_neg[l];
      s2_prod[l] <= P1W'(s1_mag[l]) * P1W'(s1_depth);
      s3_neg[l] <= s2_neg[l];
      s3_prod[l] <= P2W'(s2_prod[l]) * P2W'(inv_focal[l]);
      s4_neg[l] <= s3_neg[l];
      s4_q[l] <= sum[l][SumW-1:FracBits];
    end
    point.point_x <= s4_ok ? coord_out[0] : '0;
    point.point_y <= s4_ok ? coord_out[1] : '0;
    point.point_z <= s4_ok ? DepthW'(s4_depth) : '0;
    point.point_valid <= s4_ok;
    point.red <= s4_rgb.red;
    point.green <= s4_rgb.green;
    point.blue <= s4_rgb.blue;
  end

  // Every accepted pixel is followed by done at the end of the pipeline.
  `DP2P_ASSERT_AFTER(a_latency, accept, PipeDepth, done, "pixel did not produce a point")
  // A rejected point carries no coordinates.
  `DP2P_ASSERT_ALWAYS(a_invalid_zero, !done || point.point_valid || (point.point_x == '0 && point.point_y == '0 && point.point_z == '0), "invalid point has coordinates")
  // A valid point never has zero depth.
  `DP2P_ASSERT_ALWAYS(a_valid_depth, !done || !point.point_valid || point.point_z != '0, "valid point with zero depth")

endmodule
